// ===== rtl/wms_pkg.sv =====
`timescale 1ns / 1ps
// types, codes and sizes shared by the window match search block
// no dependencies

package wms_pkg;

	// result codes
	localparam logic [1:0] STATUS_FOUND    = 2'd0;
	localparam logic [1:0] STATUS_EMPTY    = 2'd1;
	localparam logic [1:0] STATUS_FILTERED = 2'd2;

	// configuration port
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	localparam logic [CFG_INDEX_W-1:0] REG_MATCH_ON_PID = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_MATCH_VALUE  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_VISIBLE_ONLY = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_VISIBLE_MASK = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_KEEP_LAST    = 3'd4;

	localparam logic [7:0] VISIBLE_MASK_RESET = 8'hff;

	// queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic        entry_present;
		logic [15:0] entry_pid;
		logic [7:0]  entry_cpu;
		logic [7:0]  entry_visible;
		logic        last_in_window;
	} entry_t;

	typedef struct packed {
		logic [1:0]  search_status;
		logic [15:0] found_value;
	} result_t;

	// an entry after classification
	typedef struct packed {
		logic        hit;        // matches and passes the visibility test
		logic        filt;       // matches but fails the visibility test
		logic        keep_last;
		logic [15:0] report;
		logic [7:0]  vis;
		logic        last;
	} cls_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

// ===== rtl/wms_front.sv =====
`timescale 1ns / 1ps
// front end: configuration registers and classification of each entry
// depends on wms_pkg

module wms_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [wms_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [wms_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  wms_pkg::entry_t                   entry,
	output wms_pkg::cls_t                     cls
);
	import wms_pkg::*;

	logic        match_on_pid_q;
	logic [15:0] match_value_q;
	logic        visible_only_q;
	logic [7:0]  visible_mask_q;
	logic        keep_last_q;

	logic [15:0] key;
	logic        match;
	logic        blocked;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_on_pid_q <= 1'b0;
			match_value_q  <= 16'd0;
			visible_only_q <= 1'b0;
			visible_mask_q <= VISIBLE_MASK_RESET;
			keep_last_q    <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MATCH_ON_PID: match_on_pid_q <= cfg_data[0];
				REG_MATCH_VALUE:  match_value_q  <= cfg_data[15:0];
				REG_VISIBLE_ONLY: visible_only_q <= cfg_data[0];
				REG_VISIBLE_MASK: visible_mask_q <= cfg_data[7:0];
				REG_KEEP_LAST:    keep_last_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// cpu is compared zero-extended
	assign key     = match_on_pid_q ? entry.entry_pid : {8'd0, entry.entry_cpu};
	assign match   = entry.entry_present && (key == match_value_q);
	assign blocked = visible_only_q && ((entry.entry_visible & visible_mask_q) == 8'd0);

	always_comb begin
		cls.hit       = match && !blocked;
		cls.filt      = match && blocked;
		cls.keep_last = keep_last_q;
		cls.report    = match_on_pid_q ? {8'd0, entry.entry_cpu} : entry.entry_pid;
		cls.vis       = entry.entry_visible;
		cls.last      = entry.last_in_window;
	end

endmodule

// ===== rtl/wms_queue.sv =====
`timescale 1ns / 1ps
// short queue of classified entries between front and back
// depends on wms_pkg

module wms_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr,
	input  wms_pkg::cls_t   wr_item,
	input  logic            rd,
	output wms_pkg::cls_t   head,
	output wms_pkg::qstat_t stat
);
	import wms_pkg::*;

	cls_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_wr;
	logic              do_rd;

	assign stat.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_wr      = wr && !stat.full;
	assign do_rd      = rd && !stat.empty;
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/wms_back.sv =====
`timescale 1ns / 1ps
// back end: window state, result selection and output register
// depends on wms_pkg

module wms_back (
	input  logic            clk,
	input  logic            arst_n,
	input  wms_pkg::cls_t   head,
	input  wms_pkg::qstat_t qstat,
	output logic            q_pop,
	output logic            empty,
	input  logic            pop,
	output wms_pkg::result_t result
);
	import wms_pkg::*;

	logic        have_hit_q;
	logic [15:0] hit_value_q;
	logic [7:0]  hit_visible_q;
	logic        saw_filtered_q;
	logic        out_valid_q;
	result_t     result_q;

	logic        take;
	logic        upd;
	logic        nx_have;
	logic [15:0] nx_value;
	logic [7:0]  nx_vis;
	logic        nx_filt;
	result_t     nx_result;

	// a closing entry waits until the output register is free
	assign q_pop = !qstat.empty && (!head.last || !out_valid_q || pop);
	assign take  = q_pop;
	assign upd   = head.hit && (!have_hit_q || head.keep_last);

	always_comb begin
		nx_have  = have_hit_q || upd;
		nx_value = upd ? head.report : hit_value_q;
		nx_vis   = upd ? head.vis : hit_visible_q;
		nx_filt  = saw_filtered_q || head.filt;
		priority if (nx_have && (nx_vis != 8'd0)) begin
			nx_result.search_status = STATUS_FOUND;
			nx_result.found_value   = nx_value;
		end else if (nx_have || nx_filt) begin
			nx_result.search_status = STATUS_FILTERED;
			nx_result.found_value   = 16'd0;
		end else begin
			nx_result.search_status = STATUS_EMPTY;
			nx_result.found_value   = 16'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_hit_q     <= 1'b0;
			hit_value_q    <= 16'd0;
			hit_visible_q  <= 8'd0;
			saw_filtered_q <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (take) begin
				if (head.last) begin
					have_hit_q     <= 1'b0;
					hit_value_q    <= 16'd0;
					hit_visible_q  <= 8'd0;
					saw_filtered_q <= 1'b0;
				end else begin
					have_hit_q     <= nx_have;
					hit_value_q    <= nx_value;
					hit_visible_q  <= nx_vis;
					saw_filtered_q <= nx_filt;
				end
			end
			if (take && head.last) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && head.last) begin
			result_q <= nx_result;
		end
	end

	assign empty  = !out_valid_q;
	assign result = result_q;

	a_pop_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !qstat.empty)
		else $error("queue popped while empty");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !pop && q_pop) |-> !head.last)
		else $error("waiting result would be overwritten");

	a_window_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(take && head.last) |=> (!have_hit_q && !saw_filtered_q && out_valid_q))
		else $error("window state not cleared after closing item");

	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (result_q.search_status != STATUS_FOUND))
			|-> (result_q.found_value == 16'd0))
		else $error("found_value nonzero without a found status");

endmodule

// ===== rtl/window_match_visible_search.sv =====
`timescale 1ns / 1ps
// top level of the window match search: front, queue and back wired together
// depends on wms_pkg, wms_front, wms_queue, wms_back
//
//  channel   handshake           payload                  item is taken when
//  -------   -----------------   ----------------------   ----------------------
//  entry     push / full         entry (wms_pkg::entry_t) push && !full
//  result    empty / pop         result (result_t)        pop && !empty
//  config    cfg_valid/cfg_ready cfg_index, cfg_data      cfg_valid && cfg_ready
//
// one entry item is taken every cycle while full is low; each is judged in the front in the cycle it is taken
// a window's result reaches the result ports after its closing item is taken:
// the item is first written into the two-entry queue, then the back end loads the output register
// reset clears the queue, the window state and the output valid flag, and puts the
// registers to their reset values (visible_mask all ones, the rest zero)
// while a result waits to be popped, entries that do not close a window still drain;
// a closing item waits at the queue head, and full rises once the queue holds two items
// configuration writes are always taken (cfg_ready is tied high)

module window_match_visible_search (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  wms_pkg::entry_t                 entry,
	output logic                            empty,
	input  logic                            pop,
	output wms_pkg::result_t                result,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [wms_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [wms_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import wms_pkg::*;

	cls_t   front_cls;   // classified entry from the front
	cls_t   q_head;      // oldest classified entry in the queue
	qstat_t q_stat;
	logic   q_pop;

	// front: registers and the compare / mask test
	wms_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.entry     (entry),
		.cls       (front_cls)
	);

	// decoupling queue, written straight from the input handshake
	wms_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (push),
		.wr_item (front_cls),
		.rd      (q_pop),
		.head    (q_head),
		.stat    (q_stat)
	);

	assign full = q_stat.full;

	// back: first or last hit kept, result chosen on the closing item
	wms_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (q_head),
		.qstat  (q_stat),
		.q_pop  (q_pop),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

endmodule
